### hdl/assert_macros.svh
// Assertion macros used by the RTL file of the autocall payoff block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/app_pkg.sv
// Package with widths, register indexes and a saturating helper for the autocall payoff block.
package app_pkg;

	localparam int AMT_W  = 32;
	localparam int DF_W   = 17;
	localparam int VAL_W  = 40;
	localparam int FRAC_W = 16;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
	localparam logic [AMT_W-1:0] NOTIONAL_RST = 32'd65536;

	// Register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_COUPON   = 2'd0,
		REG_BARRIER  = 2'd1,
		REG_NOTIONAL = 2'd2,
		REG_STYLE    = 2'd3
	} cfg_reg_t;

	// Coupon styles.
	localparam logic STYLE_ADDITIVE = 1'b0;
	localparam logic STYLE_MEMORY   = 1'b1;

	// A saturated value together with the flag that says it clipped.
	typedef struct packed {
		logic             sat;
		logic [VAL_W-1:0] value;
	} sat_val_t;

	// Add two 40-bit values, clipping at the all-ones maximum.
	function automatic sat_val_t sat_add(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
		logic [VAL_W:0] sum;
		sat_val_t       res;
		sum = {1'b0, a} + {1'b0, b};
		res.sat   = sum[VAL_W];
		res.value = sum[VAL_W] ? VAL_MAX : sum[VAL_W-1:0];
		return res;
	endfunction

endpackage

### hdl/autocall_path_payoff.sv
// Autocallable knock-out payoff: one path observation per beat, path value at the last one.
// A last observation is registered in the input stage, and its path value then in the output register.
// Throughput: one observation per cycle while in_stall is low; the path state loop is one add-add-multiply pass.
// in_stall rises only while a last observation waits behind an unaccepted result.
// Reset clears the path state, the pipeline valids and the registers (notional to 1.0).
module autocall_path_payoff (
	input  logic                         clk,
	input  logic                         arst_n,
	// Observation channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [app_pkg::AMT_W-1:0]    spot_level,
	input  logic [app_pkg::DF_W-1:0]     discount_factor,
	input  logic                         last_observation,
	// Result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [app_pkg::VAL_W-1:0]    path_value,
	output logic                         value_saturated,
	// Register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [app_pkg::ADDR_W-1:0]   paddr,
	input  logic [app_pkg::DATA_W-1:0]   pwdata,
	output logic [app_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	import app_pkg::*;

	`include "assert_macros.svh"

	localparam int PC_W = DF_W + AMT_W;
	localparam int PM_W = DF_W + VAL_W;

	// Configuration registers
	logic [AMT_W-1:0] coupon_q;
	logic [AMT_W-1:0] barrier_q;
	logic [AMT_W-1:0] notional_q;
	logic             style_q;

	// Input stage
	logic             valid_s1;
	logic [AMT_W-1:0] spot_s1;
	logic [DF_W-1:0]  df_s1;
	logic             last_s1;

	// Path state
	logic [VAL_W-1:0] accrued_q;
	logic [VAL_W-1:0] running_q;
	logic             knocked_q;
	logic             sat_q;

	// Output register
	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_sat_q;

	logic             cfg_wr;
	cfg_reg_t         cfg_sel;
	logic             advance;
	logic             terminate;
	sat_val_t         acc_new;
	sat_val_t         total;
	logic [PM_W-1:0]  prod_mem;
	logic [PM_W-FRAC_W-1:0] pm_shift;
	logic [PC_W-1:0]  prod_cpn;
	logic [PC_W-1:0]  prod_ntl;
	sat_val_t         add_cpn;
	sat_val_t         add_ntl;
	logic [VAL_W-1:0] accrued_n;
	logic [VAL_W-1:0] running_n;
	logic             knocked_n;
	logic             sat_n;

	// Register port decode; pready is always high.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_sel = cfg_reg_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coupon_q   <= '0;
			barrier_q  <= '0;
			notional_q <= NOTIONAL_RST;
			style_q    <= STYLE_ADDITIVE;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_COUPON:   coupon_q   <= pwdata[AMT_W-1:0];
				REG_BARRIER:  barrier_q  <= pwdata[AMT_W-1:0];
				REG_NOTIONAL: notional_q <= pwdata[AMT_W-1:0];
				REG_STYLE:    style_q    <= pwdata[0];
				default:      ;
			endcase
		end
	end

	// Register read mux.
	always_comb begin
		case (cfg_sel)
			REG_COUPON:   prdata = DATA_W'(coupon_q);
			REG_BARRIER:  prdata = DATA_W'(barrier_q);
			REG_NOTIONAL: prdata = DATA_W'(notional_q);
			REG_STYLE:    prdata = DATA_W'(style_q);
			default:      prdata = '0;
		endcase
	end

	// The input stage moves on unless it holds a last observation and the result slot is taken.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			spot_s1 <= spot_level;
			df_s1   <= discount_factor;
			last_s1 <= last_observation;
		end
	end

	// Memory style: accrue the coupon, then discount accrued plus notional on termination.
	assign terminate = (spot_s1 >= barrier_q) || last_s1;
	assign acc_new   = sat_add(accrued_q, VAL_W'(coupon_q));
	assign total     = sat_add(acc_new.value, VAL_W'(notional_q));
	assign prod_mem  = PM_W'(df_s1) * PM_W'(total.value);
	assign pm_shift  = prod_mem[PM_W-1:FRAC_W];

	// Additive style: discounted coupon every beat, discounted notional on termination.
	assign prod_cpn = PC_W'(df_s1) * PC_W'(coupon_q);
	assign prod_ntl = PC_W'(df_s1) * PC_W'(notional_q);
	assign add_cpn  = sat_add(running_q, VAL_W'(prod_cpn[PC_W-1:FRAC_W]));
	assign add_ntl  = sat_add(add_cpn.value, VAL_W'(prod_ntl[PC_W-1:FRAC_W]));

	// Next path state for the observation in the input stage.
	always_comb begin
		accrued_n = accrued_q;
		running_n = running_q;
		knocked_n = knocked_q;
		sat_n     = sat_q;
		if (!knocked_q) begin
			if (style_q == STYLE_MEMORY) begin
				accrued_n = acc_new.value;
				sat_n     = sat_n | acc_new.sat;
				if (terminate) begin
					running_n = pm_shift[VAL_W] ? VAL_MAX : pm_shift[VAL_W-1:0];
					sat_n     = sat_n | total.sat | pm_shift[VAL_W];
				end
			end else begin
				running_n = add_cpn.value;
				sat_n     = sat_n | add_cpn.sat;
				if (terminate) begin
					running_n = add_ntl.value;
					sat_n     = sat_n | add_ntl.sat;
				end
			end
			knocked_n = knocked_n | terminate;
		end
	end

	// Path state update; a last observation clears the path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accrued_q <= '0;
			running_q <= '0;
			knocked_q <= 1'b0;
			sat_q     <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				accrued_q <= '0;
				running_q <= '0;
				knocked_q <= 1'b0;
				sat_q     <= 1'b0;
			end else begin
				accrued_q <= accrued_n;
				running_q <= running_n;
				knocked_q <= knocked_n;
				sat_q     <= sat_n;
			end
		end
	end

	// Output register holds the finished path value until the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_value_q <= running_n;
			out_sat_q   <= sat_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign path_value      = out_value_q;
	assign value_saturated = out_sat_q;

	// A last observation always produces a result beat.
	`ASSERT_CLK(a_last_emits, clk, arst_n, advance && last_s1 |=> out_valid_q, "last observation gave no result")
	// The path state is empty after a result is produced.
	`ASSERT_CLK(a_state_clear, clk, arst_n, advance && last_s1 |=> (running_q == '0) && (accrued_q == '0) && !knocked_q && !sat_q, "path state not cleared")
	// A knocked-out path keeps its value until the last observation.
	`ASSERT_CLK(a_knocked_hold, clk, arst_n, advance && knocked_q && !last_s1 |=> $stable(running_q) && knocked_q, "knocked-out path changed")
	// Back-pressure only arises from a waiting last observation behind a full result slot.
	`ASSERT_CLK_ALWAYS(a_stall_cause, clk, !in_stall || (valid_s1 && last_s1 && out_valid_q && out_stall), "input stalled without cause")

endmodule

### tb/payoff_checker.sv
// Checker for the autocall payoff block: tracks register writes, predicts path values, compares results.
module payoff_checker
	import app_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [AMT_W-1:0]    spot_level,
	input  logic [DF_W-1:0]     discount_factor,
	input  logic                last_observation,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [VAL_W-1:0]    path_value,
	input  logic                value_saturated,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	input  logic                pready,
	output int unsigned         error_count,
	output int unsigned         pending_results
);

	// One expected path result.
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             sat;
	} payoff_t;

	localparam logic [63:0] VALUE_CEIL = 64'(VAL_MAX);

	// Shadow copy of the registers.
	logic [AMT_W-1:0] coupon_q;
	logic [AMT_W-1:0] barrier_q;
	logic [AMT_W-1:0] notional_q;
	logic             style_q;

	// Predicted path state.
	logic [VAL_W-1:0] coupons_held;
	logic [VAL_W-1:0] value_so_far;
	logic             path_done;
	logic             path_clipped;

	// Path results still owed by the block, oldest first.
	payoff_t          payoff_q[$];

	// Clip a wide value at the 40-bit ceiling and remember that it clipped.
	function automatic logic [VAL_W-1:0] clip40(input logic [63:0] x);
		if (x > VALUE_CEIL) begin
			path_clipped = 1'b1;
			return VAL_MAX;
		end
		return x[VAL_W-1:0];
	endfunction

	// Print one line per mismatch and count it.
	task automatic flag_error(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("payoff_checker: %s mismatch, got %0h expected %0h at %0t", what, got, want,
			$realtime);
		error_count = error_count + 1;
	endtask

	// Apply one observation to the predicted path and queue the path value on its last one.
	task automatic advance_path(input logic [AMT_W-1:0] spot, input logic [DF_W-1:0] df,
			input logic last_obs);
		logic             ends_here;
		logic [VAL_W-1:0] owed;
		payoff_t          done_path;
		if (!path_done) begin
			ends_here = (spot >= barrier_q) || last_obs;
			if (style_q == STYLE_MEMORY) begin
				// Coupons pile up and are paid with the notional when the path ends.
				coupons_held = clip40(64'(coupons_held) + 64'(coupon_q));
				if (ends_here) begin
					owed = clip40(64'(coupons_held) + 64'(notional_q));
					value_so_far = clip40((64'(df) * 64'(owed)) >> FRAC_W);
				end
			end else begin
				// Each observation pays its discounted coupon straight away.
				value_so_far = clip40(64'(value_so_far) +
					64'(clip40((64'(df) * 64'(coupon_q)) >> FRAC_W)));
				if (ends_here)
					value_so_far = clip40(64'(value_so_far) +
						64'(clip40((64'(df) * 64'(notional_q)) >> FRAC_W)));
			end
			if (ends_here)
				path_done = 1'b1;
		end
		if (last_obs) begin
			done_path.value = value_so_far;
			done_path.sat   = path_clipped;
			payoff_q = {payoff_q, done_path};
			coupons_held = '0;
			value_so_far = '0;
			path_done    = 1'b0;
			path_clipped = 1'b0;
		end
	endtask

	// Watch all three ports at each clock edge.
	always @(posedge clk or negedge arst_n) begin
		payoff_t want;
		if (!arst_n) begin
			coupon_q     = '0;
			barrier_q    = '0;
			notional_q   = NOTIONAL_RST;
			style_q      = STYLE_ADDITIVE;
			coupons_held = '0;
			value_so_far = '0;
			path_done    = 1'b0;
			path_clipped = 1'b0;
			error_count  = 0;
			payoff_q.delete();
			pending_results <= 0;
		end else begin
			// Compare a result beat with the oldest expectation.
			if (out_valid && !out_stall) begin
				if (payoff_q.size() == 0) begin
					flag_error("unexpected result, path_value", 64'(path_value), 64'd0);
				end else begin
					want = payoff_q.pop_front();
					if (path_value !== want.value)
						flag_error("path_value", 64'(path_value), 64'(want.value));
					if (value_saturated !== want.sat)
						flag_error("value_saturated", 64'(value_saturated), 64'(want.sat));
				end
			end
			// Follow register writes.
			if (psel && penable && pwrite && pready) begin
				case (cfg_reg_t'(paddr[ADDR_W-1:2]))
					REG_COUPON:   coupon_q   = pwdata[AMT_W-1:0];
					REG_BARRIER:  barrier_q  = pwdata[AMT_W-1:0];
					REG_NOTIONAL: notional_q = pwdata[AMT_W-1:0];
					REG_STYLE:    style_q    = pwdata[0];
					default: ;
				endcase
			end
			// Predict from an accepted observation beat.
			if (in_valid && !in_stall)
				advance_path(spot_level, discount_factor, last_observation);
			pending_results <= payoff_q.size();
		end
	end

endmodule

### tb/tb.sv
// Testbench top for the autocall payoff block: clock, reset, stimulus, back-pressure and verdict.
module tb;
	import app_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int LONG_PATH      = 140;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [AMT_W-1:0]    spot_level;
	logic [DF_W-1:0]     discount_factor;
	logic                last_observation;
	logic                out_valid;
	logic                out_stall;
	logic [VAL_W-1:0]    path_value;
	logic                value_saturated;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	int unsigned         error_count;
	int unsigned         pending_results;

	// Idling rates in percent, the barrier now in force and the hold-off request.
	int unsigned         tx_gap_pct;
	int unsigned         rx_stall_pct;
	logic [AMT_W-1:0]    cur_barrier;
	bit                  hold_request;

	autocall_path_payoff u_top (.*);

	payoff_checker u_checker (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: random stalls, or one long hold-off on request.
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99, 0) < rx_stall_pct);
			end
		end
	end

	// Watchdog: ends the run after too long without any accepted beat.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: done, errors");
		$finish;
	end

	// Wait until every expected path value has come out and the pipeline is quiet.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [AMT_W-1:0] cpn, input logic [AMT_W-1:0] bar,
			input logic [AMT_W-1:0] notl, input logic style);
		write_reg(REG_COUPON, cpn);
		write_reg(REG_BARRIER, bar);
		write_reg(REG_NOTIONAL, notl);
		write_reg(REG_STYLE, 32'(style));
		cur_barrier = bar;
	endtask

	// Offer one observation beat, after a random gap, and hold it until it is taken.
	task automatic send_obs(input logic [AMT_W-1:0] spot, input logic [DF_W-1:0] df,
			input logic last_obs);
		while ($urandom_range(99, 0) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		spot_level       <= spot;
		discount_factor  <= df;
		last_observation <= last_obs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Spot mix: extremes, exactly at the barrier, just under it, anywhere, or below it.
	function automatic logic [AMT_W-1:0] pick_spot();
		case ($urandom_range(9, 0))
			0: return '0;
			1: return '1;
			2: return cur_barrier;
			3: return cur_barrier - 1;
			4, 5: return $urandom;
			default: return (cur_barrier == 0) ? '0 : $urandom_range(cur_barrier - 1, 0);
		endcase
	endfunction

	// Discount mix: zero, one, the top of Q1.16, anywhere, or a typical value.
	function automatic logic [DF_W-1:0] pick_df();
		case ($urandom_range(7, 0))
			0: return '0;
			1: return 17'd65536;
			2: return 17'd131071;
			3: return DF_W'($urandom_range(131071, 0));
			default: return DF_W'($urandom_range(65536, 30000));
		endcase
	endfunction

	task automatic send_path(input int len);
		for (int i = 0; i < len; i++)
			send_obs(pick_spot(), pick_df(), i == len - 1);
	endtask

	// A long path under the barrier with large discounts, enough to clip the value.
	task automatic send_long_path();
		for (int i = 0; i < LONG_PATH; i++)
			send_obs($urandom_range(32'hFFFF_FFFE, 0),
				(i == LONG_PATH - 1) ? 17'd131071 : DF_W'($urandom_range(131071, 125000)),
				i == LONG_PATH - 1);
	endtask

	// Stimulus.
	initial begin
		int               count;
		int               len;
		logic [AMT_W-1:0] cpn;
		logic [AMT_W-1:0] bar;
		logic [AMT_W-1:0] notl;
		arst_n           <= 1'b0;
		in_valid         <= 1'b0;
		spot_level       <= '0;
		discount_factor  <= '0;
		last_observation <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		tx_gap_pct   = 8;
		rx_stall_pct = 84;
		cur_barrier  = '0;
		hold_request = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at reset: a zero barrier ends the path at once, paying the 1.0 notional.
		send_obs('0, 17'd65536, 1'b1);
		drain();

		// Additive path that knocks out at the top spot; the following beats are ignored.
		write_reg(REG_COUPON, 32'h0001_0000);
		write_reg(REG_BARRIER, 32'hFFFF_FFFF);
		write_reg(REG_NOTIONAL, 32'h0064_0000);
		send_obs('0, 17'd65536, 1'b0);
		send_obs(32'h7FFF_FFFF, 17'd60000, 1'b0);
		send_obs(32'hFFFF_FFFF, 17'd50000, 1'b0);
		send_obs('0, 17'd131071, 1'b0);
		send_obs(32'hFFFF_FFFF, '0, 1'b1);
		// Discount above one, and a zero discount, on single-beat paths.
		send_obs(32'h1234_5678, 17'd131071, 1'b1);
		send_obs('0, '0, 1'b1);

		// Style switched to memory in the middle of a path.
		send_obs('0, 17'd40000, 1'b0);
		send_obs(32'd1, 17'd50000, 1'b0);
		drain();
		write_reg(REG_STYLE, 32'(STYLE_MEMORY));
		send_obs(32'd2, 17'd65536, 1'b0);
		send_obs(32'd3, 17'd131071, 1'b1);

		// Memory style knock-out followed by ignored beats.
		send_obs(32'hFFFF_FFFF, 17'd65536, 1'b0);
		send_obs('0, 17'd65536, 1'b0);
		send_obs('0, 17'd65536, 1'b1);

		// Zero notional in both styles.
		drain();
		write_reg(REG_NOTIONAL, '0);
		send_obs(32'd5, 17'd65536, 1'b0);
		send_obs(32'd6, 17'd65536, 1'b1);
		drain();
		write_reg(REG_STYLE, 32'(STYLE_ADDITIVE));
		send_obs(32'd7, 17'd65536, 1'b1);

		// Random paths over six register settings and three idling patterns.
		for (int seg = 0; seg < 6; seg++) begin
			drain();
			case (seg / 2)
				0: begin
					tx_gap_pct   = 8;
					rx_stall_pct = 84;
				end
				1: begin
					tx_gap_pct   = 84;
					rx_stall_pct = 8;
				end
				default: begin
					tx_gap_pct   = 0;
					rx_stall_pct = 0;
				end
			endcase
			case (seg)
				0: begin
					cpn  = $urandom_range(32'h2_0000, 0);
					bar  = $urandom_range(32'h3_0000, 32'h8000);
					notl = $urandom_range(32'h100_0000, 1);
				end
				1: begin
					cpn  = 32'hFFFF_FFFF;
					bar  = '0;
					notl = 32'hFFFF_FFFF;
				end
				2: begin
					cpn  = '0;
					bar  = 32'hFFFF_FFFF;
					notl = 32'd1;
				end
				3: begin
					cpn  = $urandom;
					bar  = $urandom;
					notl = $urandom | 32'd1;
				end
				4: begin
					cpn  = $urandom_range(32'h4_0000, 0);
					bar  = $urandom_range(32'h2_0000, 32'h1_0000);
					notl = 32'h1_0000;
				end
				default: begin
					cpn  = $urandom;
					bar  = $urandom_range(32'h8000_0000, 0);
					notl = $urandom;
				end
			endcase
			load_config(cpn, bar, notl, seg[0]);
			// With no random idling, the receiver holds off long enough to fill the block.
			if (seg == 4)
				hold_request = 1'b1;
			count = 0;
			while (count < 45) begin
				len = ($urandom_range(7, 0) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 1);
				send_path(len);
				count += len;
			end
			// Long paths that saturate, once per style.
			if (seg >= 4) begin
				drain();
				load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, seg[0]);
				send_long_path();
			end
		end

		drain();
		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/app_pkg.sv
hdl/autocall_path_payoff.sv
tb/payoff_checker.sv
tb/tb.sv
